// ----- hdl/asd_pkg.sv -----
// Shared types and constants of the accelerometer shake detector.
package asd_pkg;

    localparam int unsigned DATA_W  = 16;
    localparam int unsigned ACC_W   = 2 * DATA_W;
    localparam int unsigned CNT_W   = $clog2(DATA_W);

    localparam logic [DATA_W-1:0] RESET_THRESHOLD = 16'd4506;
    localparam logic [DATA_W-1:0] RESET_COOLDOWN  = 16'd900;
    localparam logic [DATA_W-1:0] ONE_G           = 16'd8192;
    localparam logic [DATA_W-1:0] COUNT_MAX       = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_TAKE   = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic {
        CFG_THRESHOLD = 1'b0,
        CFG_COOLDOWN  = 1'b1
    } t_cfg_addr;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_DONE = 3'b100
    } t_state;

endpackage

// ----- hdl/accel_shake_detector.sv -----
// Top level of the accelerometer shake detector.
// A sample request passes from acceptance to its result through a bit-serial
// shift-add squarer (all three axes at once, one multiplier bit per cycle), a
// restoring square root (one root bit per cycle), and a handoff and commit.
// Tick and take requests go straight to the commit. The block holds one
// request at a time; a finished result sits in the output register, so the
// next request is accepted while that result waits to be taken.
module accel_shake_detector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_addr,
    input  logic        [asd_pkg::DATA_W-1:0] i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic        [1:0]                 i_kind,
    input  logic signed [asd_pkg::DATA_W-1:0] i_accel_x,
    input  logic signed [asd_pkg::DATA_W-1:0] i_accel_y,
    input  logic signed [asd_pkg::DATA_W-1:0] i_accel_z,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_shake_detected,
    output logic                              o_event_taken,
    output logic        [asd_pkg::DATA_W-1:0] o_magnitude
);

    localparam int unsigned W = asd_pkg::DATA_W;

    asd_pkg::t_state   r_state, n_state;
    asd_pkg::t_kind    r_kind;

    logic [W-1:0] r_threshold;
    logic [W-1:0] r_cooldown;
    logic [W-1:0] r_last_mag, n_last_mag;
    logic [W-1:0] r_since_cnt, n_since_cnt;
    logic         r_pending, n_pending;

    logic         r_out_valid;
    logic         r_shake, n_shake;
    logic         r_taken, n_taken;
    logic [W-1:0] r_out_mag;

    logic         in_acc;
    logic         out_free;
    logic         commit;
    logic         mag_start;
    logic         mag_done;
    logic [W-1:0] new_mag;
    logic [W-1:0] delta;
    logic         detect;

    assign o_in_stall = (r_state != asd_pkg::S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign commit     = (r_state == asd_pkg::S_DONE) && out_free;
    assign mag_start  = in_acc && (asd_pkg::t_kind'(i_kind) == asd_pkg::KIND_SAMPLE);

    asd_mag u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mag_start),
        .i_x     (i_accel_x),
        .i_y     (i_accel_y),
        .i_z     (i_accel_z),
        .o_done  (mag_done),
        .o_mag   (new_mag)
    );

    assign delta  = (new_mag >= r_last_mag) ? (new_mag - r_last_mag) : (r_last_mag - new_mag);
    assign detect = (r_kind == asd_pkg::KIND_SAMPLE) && (delta >= r_threshold)
                 && (r_since_cnt >= r_cooldown);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            asd_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = mag_start ? asd_pkg::S_CALC : asd_pkg::S_DONE;
                end
            end
            asd_pkg::S_CALC: begin
                if (mag_done) begin
                    n_state = asd_pkg::S_DONE;
                end
            end
            asd_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = asd_pkg::S_IDLE;
                end
            end
            default: n_state = asd_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_last_mag  = r_last_mag;
        n_since_cnt = r_since_cnt;
        n_pending   = r_pending;
        n_shake     = 1'b0;
        n_taken     = 1'b0;
        unique case (r_kind)
            asd_pkg::KIND_SAMPLE: begin
                n_last_mag = new_mag;
                if (detect) begin
                    n_shake     = 1'b1;
                    n_pending   = 1'b1;
                    n_since_cnt = '0;
                end
            end
            asd_pkg::KIND_TICK: begin
                if (r_since_cnt != asd_pkg::COUNT_MAX) begin
                    n_since_cnt = r_since_cnt + 1'b1;
                end
            end
            asd_pkg::KIND_TAKE: begin
                n_taken   = r_pending;
                n_pending = 1'b0;
            end
            default: begin
                n_shake = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= asd_pkg::S_IDLE;
            r_threshold <= asd_pkg::RESET_THRESHOLD;
            r_cooldown  <= asd_pkg::RESET_COOLDOWN;
            r_last_mag  <= asd_pkg::ONE_G;
            r_since_cnt <= '0;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (asd_pkg::t_cfg_addr'(i_cfg_addr))
                    asd_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data;
                    asd_pkg::CFG_COOLDOWN:  r_cooldown  <= i_cfg_data;
                    default:                r_threshold <= r_threshold;
                endcase
            end
            if (commit) begin
                r_last_mag  <= n_last_mag;
                r_since_cnt <= n_since_cnt;
                r_pending   <= n_pending;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind <= asd_pkg::t_kind'(i_kind);
        end
        if (commit) begin
            r_shake   <= n_shake;
            r_taken   <= n_taken;
            r_out_mag <= n_last_mag;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_shake_detected = r_shake;
    assign o_event_taken    = r_taken;
    assign o_magnitude      = r_out_mag;

    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mag_done |-> (r_state == asd_pkg::S_CALC))
        else $error("square root finished outside of calculation");

    a_shake_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && n_shake) |=> (r_since_cnt == '0) && r_pending)
        else $error("shake did not clear counter or set pending flag");

    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_mag == r_last_mag))
        else $error("result magnitude differs from stored magnitude");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != asd_pkg::S_IDLE))
        else $error("request accepted but block stayed idle");

endmodule

// ----- hdl/asd_mag.sv -----
// Bit-serial sum of squares and restoring integer square root of a 3-axis sample.
module asd_mag (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [asd_pkg::DATA_W-1:0] i_x,
    input  logic signed [asd_pkg::DATA_W-1:0] i_y,
    input  logic signed [asd_pkg::DATA_W-1:0] i_z,
    output logic                              o_done,
    output logic        [asd_pkg::DATA_W-1:0] o_mag
);

    localparam int unsigned W  = asd_pkg::DATA_W;
    localparam int unsigned AW = asd_pkg::ACC_W;
    localparam int unsigned CW = asd_pkg::CNT_W;
    localparam int unsigned RW = W + 2;

    function automatic logic [W-1:0] f_abs(input logic [W-1:0] v);
        logic [W-1:0] r;
        r = v[W-1] ? (~v + 1'b1) : v;
        return r;
    endfunction

    logic          r_busy, n_busy;
    logic          r_sq, n_sq;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_mx, r_my, r_mz;
    logic [W-1:0]  r_bx, r_by, r_bz, n_bx, n_by, n_bz;
    logic [AW-1:0] r_acc, n_acc;
    logic [RW-1:0] r_rem, n_rem;
    logic [W-1:0]  r_root, n_root;

    logic [RW:0]   rem_sh;
    logic [RW:0]   trial;
    logic [RW:0]   diff;
    logic          last_step;

    assign rem_sh    = {r_rem[RW-2:0], r_acc[AW-1 -: 2]};
    assign trial     = {1'b0, r_root, 2'b01};
    assign diff      = rem_sh - trial;
    assign last_step = (r_cnt == CW'(W - 1));

    always_comb begin
        n_busy = r_busy;
        n_sq   = r_sq;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_bx   = r_bx;
        n_by   = r_by;
        n_bz   = r_bz;
        n_acc  = r_acc;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_start) begin
            n_busy = 1'b1;
            n_sq   = 1'b1;
            n_cnt  = '0;
            n_bx   = f_abs(i_x);
            n_by   = f_abs(i_y);
            n_bz   = f_abs(i_z);
            n_acc  = '0;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_cnt = r_cnt + 1'b1;
            if (r_sq) begin
                n_acc = {r_acc[AW-2:0], 1'b0}
                      + {{W{1'b0}}, (r_bx[W-1] ? r_mx : {W{1'b0}})}
                      + {{W{1'b0}}, (r_by[W-1] ? r_my : {W{1'b0}})}
                      + {{W{1'b0}}, (r_bz[W-1] ? r_mz : {W{1'b0}})};
                n_bx  = {r_bx[W-2:0], 1'b0};
                n_by  = {r_by[W-2:0], 1'b0};
                n_bz  = {r_bz[W-2:0], 1'b0};
                if (last_step) begin
                    n_sq = 1'b0;
                end
            end else begin
                n_acc = {r_acc[AW-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    n_rem  = diff[RW-1:0];
                    n_root = {r_root[W-2:0], 1'b1};
                end else begin
                    n_rem  = rem_sh[RW-1:0];
                    n_root = {r_root[W-2:0], 1'b0};
                end
                if (last_step) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sq   <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_sq   <= n_sq;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mx <= f_abs(i_x);
            r_my <= f_abs(i_y);
            r_mz <= f_abs(i_z);
        end
        r_bx   <= n_bx;
        r_by   <= n_by;
        r_bz   <= n_bz;
        r_acc  <= n_acc;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_mag  = r_root;

endmodule

// ----- tb/sv/accel_shake_detector_tb.sv -----
// Testbench for accel_shake_detector: directed and random requests checked by a predictor.
`timescale 1ns / 1ps

module accel_shake_detector_tb;

    localparam int DATA_W       = asd_pkg::DATA_W;
    localparam int IDLE_LIMIT   = 3000;
    localparam int TAIL_CYCLES  = 60;
    localparam int RANDOM_ITEMS = 500;
    localparam int PHASES       = 6;

    typedef struct packed {
        logic              shake;
        logic              taken;
        logic [DATA_W-1:0] mag;
    } t_reading;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic                     i_cfg_addr;
    logic [DATA_W-1:0]        i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [1:0]               i_kind;
    logic signed [DATA_W-1:0] i_accel_x;
    logic signed [DATA_W-1:0] i_accel_y;
    logic signed [DATA_W-1:0] i_accel_z;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic                     o_shake_detected;
    logic                     o_event_taken;
    logic [DATA_W-1:0]        o_magnitude;

    t_reading          expected_readings[$];
    logic [DATA_W-1:0] thr_q;
    logic [DATA_W-1:0] cool_q;
    logic [DATA_W-1:0] last_mag_q;
    logic [DATA_W-1:0] since_tick_q;
    logic              pending_q;
    int                fail_count  = 0;
    int                idle_cycles = 0;
    bit                idle_on     = 1'b0;

    accel_shake_detector DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_accel_x        (i_accel_x),
        .i_accel_y        (i_accel_y),
        .i_accel_z        (i_accel_z),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_shake_detected (o_shake_detected),
        .o_event_taken    (o_event_taken),
        .o_magnitude      (o_magnitude)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [DATA_W-1:0] floor_sqrt(input logic [33:0] n);
        logic [DATA_W-1:0] root;
        logic [DATA_W-1:0] trial;
        logic [33:0]       sq;
        root = '0;
        for (int b = DATA_W - 1; b >= 0; b--) begin
            trial = root | (16'd1 << b);
            sq    = 34'(trial) * 34'(trial);
            if (sq <= n) root = trial;
        end
        return root;
    endfunction

    function automatic logic [16:0] axis_abs(input logic signed [DATA_W-1:0] v);
        logic signed [16:0] w;
        w = 17'(v);
        return (w < 0) ? 17'(-w) : 17'(w);
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        return DATA_W'($urandom_range(0, 65535));
    endfunction

    // mode 0: any bits, 1: extremes, 2: near center, 3: strong jolt around center
    function automatic logic [DATA_W-1:0] pick_axis(input int mode, input int center);
        int spread;
        case (mode)
            0: return rand_word();
            1: begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            default: begin
                spread = (mode == 2) ? 600 : 24000;
                return DATA_W'(center + int'($urandom_range(0, 2 * spread)) - spread);
            end
        endcase
    endfunction

    task automatic step_detector(input logic [1:0] kind, input logic signed [DATA_W-1:0] ax,
                                 input logic signed [DATA_W-1:0] ay,
                                 input logic signed [DATA_W-1:0] az);
        t_reading          r;
        logic [33:0]       sumsq;
        logic [DATA_W-1:0] mag;
        logic [DATA_W-1:0] delta;
        r = '0;
        case (asd_pkg::t_kind'(kind))
            asd_pkg::KIND_SAMPLE: begin
                sumsq = 34'(axis_abs(ax)) * 34'(axis_abs(ax))
                      + 34'(axis_abs(ay)) * 34'(axis_abs(ay))
                      + 34'(axis_abs(az)) * 34'(axis_abs(az));
                mag   = floor_sqrt(sumsq);
                delta = (mag >= last_mag_q) ? mag - last_mag_q : last_mag_q - mag;
                if (delta >= thr_q && since_tick_q >= cool_q) begin
                    r.shake      = 1'b1;
                    pending_q    = 1'b1;
                    since_tick_q = '0;
                end
                last_mag_q = mag;
            end
            asd_pkg::KIND_TICK: begin
                if (since_tick_q != asd_pkg::COUNT_MAX) since_tick_q = since_tick_q + 1'b1;
            end
            asd_pkg::KIND_TAKE: begin
                r.taken   = pending_q;
                pending_q = 1'b0;
            end
            default: ;
        endcase
        r.mag = last_mag_q;
        expected_readings.push_back(r);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thr_q        = asd_pkg::RESET_THRESHOLD;
            cool_q       = asd_pkg::RESET_COOLDOWN;
            last_mag_q   = asd_pkg::ONE_G;
            since_tick_q = '0;
            pending_q    = 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (asd_pkg::t_cfg_addr'(i_cfg_addr))
                    asd_pkg::CFG_THRESHOLD: thr_q = i_cfg_data;
                    asd_pkg::CFG_COOLDOWN:  cool_q = i_cfg_data;
                endcase
            end
            if (i_in_valid && !o_in_stall) step_detector(i_kind, i_accel_x, i_accel_y, i_accel_z);
        end
    end

    task automatic report_field(input string field, input logic [DATA_W-1:0] want,
                                input logic [DATA_W-1:0] got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        fail_count++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_reading want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_readings.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual shake=%0b taken=%0b mag=%0d",
                         $time, o_shake_detected, o_event_taken, o_magnitude);
                fail_count++;
            end else begin
                want = expected_readings.pop_front();
                if (o_shake_detected !== want.shake)
                    report_field("shake_detected", DATA_W'(want.shake),
                                 DATA_W'(o_shake_detected));
                if (o_event_taken !== want.taken)
                    report_field("event_taken", DATA_W'(want.taken), DATA_W'(o_event_taken));
                if (o_magnitude !== want.mag)
                    report_field("magnitude", want.mag, o_magnitude);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : out_stall_driver
        int n;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 15);
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_request(input asd_pkg::t_kind kind, input logic [DATA_W-1:0] x,
                                input logic [DATA_W-1:0] y, input logic [DATA_W-1:0] z);
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_accel_x  <= x;
        i_accel_y  <= y;
        i_accel_z  <= z;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    task automatic drain_requests();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_readings.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_limits(input logic [DATA_W-1:0] threshold,
                              input logic [DATA_W-1:0] cooldown);
        drain_requests();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= asd_pkg::CFG_THRESHOLD;
        i_cfg_data <= threshold;
        @(posedge i_clk);
        i_cfg_addr <= asd_pkg::CFG_COOLDOWN;
        i_cfg_data <= cooldown;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic test_reset_values();
        send_request(asd_pkg::KIND_SAMPLE, 16'h0000, 16'h0000, 16'd8192);
        send_request(asd_pkg::KIND_SAMPLE, 16'h0000, 16'h0000, 16'hE000);
        send_request(asd_pkg::KIND_TAKE, rand_word(), rand_word(), rand_word());
        send_request(asd_pkg::KIND_NONE, rand_word(), rand_word(), rand_word());
    endtask

    task automatic test_extreme_samples();
        set_limits(16'd0, 16'd0);
        send_request(asd_pkg::KIND_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
        send_request(asd_pkg::KIND_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_request(asd_pkg::KIND_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
        send_request(asd_pkg::KIND_TAKE, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_request(asd_pkg::KIND_TAKE, 16'hFFFF, 16'h0000, 16'h8000);
        send_request(asd_pkg::KIND_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(asd_pkg::KIND_NONE, 16'h8000, 16'h8000, 16'h8000);
        send_request(asd_pkg::KIND_SAMPLE, 16'hFFFF, 16'h0001, 16'h0000);
    endtask

    task automatic test_cooldown();
        set_limits(16'd1000, 16'd3);
        send_request(asd_pkg::KIND_SAMPLE, 16'h0000, 16'd8192, 16'h0000);
        repeat (3) send_request(asd_pkg::KIND_TICK, rand_word(), rand_word(), rand_word());
        send_request(asd_pkg::KIND_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
        send_request(asd_pkg::KIND_SAMPLE, 16'h0000, 16'd20000, 16'h0000);
        repeat (3) send_request(asd_pkg::KIND_TICK, rand_word(), rand_word(), rand_word());
        send_request(asd_pkg::KIND_SAMPLE, 16'h0000, 16'd20500, 16'h0000);
        send_request(asd_pkg::KIND_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
        send_request(asd_pkg::KIND_TAKE, rand_word(), rand_word(), rand_word());
    endtask

    task automatic test_random_traffic();
        int                sent;
        int                pick;
        int                mode;
        int                burst;
        logic [DATA_W-1:0] ax;
        logic [DATA_W-1:0] ay;
        logic [DATA_W-1:0] az;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: set_limits(16'd0, 16'd0);
                1: set_limits(16'hFFFF, 16'hFFFF);
                2: set_limits(asd_pkg::RESET_THRESHOLD, 16'd40);
                3: set_limits(DATA_W'($urandom_range(0, 3000)), DATA_W'($urandom_range(0, 8)));
                4: set_limits(DATA_W'($urandom_range(1000, 30000)),
                              DATA_W'($urandom_range(0, 20)));
                default: begin
                    set_limits(DATA_W'($urandom_range(0, 12000)), DATA_W'($urandom_range(0, 10)));
                    idle_on = 1'b0;
                end
            endcase
            sent = 0;
            while (sent < RANDOM_ITEMS / PHASES) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    mode = $urandom_range(0, 9);
                    mode = (mode < 2) ? 0 : (mode == 2) ? 1 : (mode < 5) ? 3 : 2;
                    ax = pick_axis(mode, 0);
                    ay = pick_axis(mode, 0);
                    az = pick_axis(mode, 8192);
                    send_request(asd_pkg::KIND_SAMPLE, ax, ay, az);
                    sent++;
                end else if (pick < 75) begin
                    burst = $urandom_range(1, 12);
                    repeat (burst)
                        send_request(asd_pkg::KIND_TICK, rand_word(), rand_word(), rand_word());
                    sent += burst;
                end else if (pick < 92) begin
                    send_request(asd_pkg::KIND_TAKE, rand_word(), rand_word(), rand_word());
                    sent++;
                end else if (pick < 97) begin
                    send_request(asd_pkg::KIND_NONE, rand_word(), rand_word(), rand_word());
                end else begin
                    drain_requests();
                end
            end
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_addr <= asd_pkg::CFG_THRESHOLD;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_kind     <= asd_pkg::KIND_SAMPLE;
        i_accel_x  <= '0;
        i_accel_y  <= '0;
        i_accel_z  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n    <= 1'b1;
        idle_on = 1'b1;
        test_reset_values();
        test_extreme_samples();
        test_cooldown();
        test_random_traffic();
        drain_requests();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/asd_pkg.sv
hdl/asd_mag.sv
hdl/accel_shake_detector.sv
tb/sv/accel_shake_detector_tb.sv
